@@ hw/rtl/cfq_pkg.sv @@
// Shared types and constants for the circular FIFO queue.
package cfq_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int OP_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    // Register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2
    } t_opcode;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [DATA_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
    } t_out_item;

endpackage

@@ hw/rtl/cfq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cfq_ram import cfq_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/circular_fifo_queue.sv @@
// Top level of the circular FIFO queue: control, slot RAM and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//  out     | from block| o_out_valid/ i_out_ready| o_out_data (t_out_item)
//  config  | to block  | APB psel/penable/pready | capacity at byte address 0
//
//  One operation is taken per clock while no result beat stalls. The slot RAM
//  read issues at the accepting edge, as the pending stage loads; the result
//  register loads from the pending stage. Unstalled, the rate is one beat per cycle.
//  Reset (synchronous, active low) empties the queue and sets capacity to 16;
//  the slot RAM is not cleared. A stalled result beat holds the pending stage,
//  which in turn holds o_in_ready low until the result moves on.
module circular_fifo_queue import cfq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam int CMP_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

    // Configuration register
    logic [CNT_W-1:0] r_capacity;
    logic [CNT_W-1:0] cap_use;
    logic             cfg_write;

    // Queue control state
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;
    logic [CNT_W-1:0] n_count;

    // Pending stage: decision made, RAM read data registered alongside it
    logic             r_pend_valid;
    logic             r_pend_ok;
    logic             r_pend_rd;
    logic [CNT_W-1:0] r_pend_count;
    logic             r_pend_full;

    // Result register
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_fire;
    logic             pend_move;
    logic             is_full_now;
    logic             is_empty_now;
    logic             op_ok;
    logic             op_rd;
    logic             ram_we;
    logic             ram_re;
    logic [DATA_W-1:0] ram_rdata;

    // ---------------------------------------------------------------------
    // Configuration port: always ready, write in the access phase.
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[CNT_W-1:0];
        end
    end

    // Clamp capacity: zero acts as one, anything above the built depth as DEPTH.
    always_comb begin
        if (r_capacity == '0) begin
            cap_use = CNT_W'(1);
        end else if (int'(r_capacity) > CAP_MAX) begin
            cap_use = CNT_W'(CAP_MAX);
        end else begin
            cap_use = r_capacity;
        end
    end

    // ---------------------------------------------------------------------
    // Handshakes: the pending stage drains into the result register whenever
    // that register is free or being emptied; a new beat enters behind it.
    // ---------------------------------------------------------------------
    assign pend_move  = r_pend_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend_valid || pend_move;
    assign in_fire    = i_in_valid && o_in_ready;

    assign is_full_now  = r_count >= cap_use;
    assign is_empty_now = r_count == '0;

    // ---------------------------------------------------------------------
    // Operation decode: decide success, advance pointers and count, and
    // drive the RAM. Refused and unknown operations touch nothing.
    // ---------------------------------------------------------------------
    always_comb begin
        op_ok   = 1'b0;
        op_rd   = 1'b0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        unique case (i_in_data.opcode)
            OP_ENQUEUE: begin
                if (!is_full_now) begin
                    op_ok   = 1'b1;
                    ram_we  = in_fire;
                    n_count = r_count + CNT_W'(1);
                    n_tail  = (CMP_W'(r_tail) + CMP_W'(1) >= CMP_W'(cap_use))
                              ? '0 : r_tail + PTR_W'(1);
                end
            end
            OP_DEQUEUE: begin
                if (!is_empty_now) begin
                    op_ok   = 1'b1;
                    op_rd   = 1'b1;
                    ram_re  = in_fire;
                    n_count = r_count - CNT_W'(1);
                    n_head  = (CMP_W'(r_head) + CMP_W'(1) >= CMP_W'(cap_use))
                              ? '0 : r_head + PTR_W'(1);
                end
            end
            OP_PEEK: begin
                if (!is_empty_now) begin
                    op_ok  = 1'b1;
                    op_rd  = 1'b1;
                    ram_re = in_fire;
                end
            end
            default: begin
                // unknown code: no operation, report the unchanged queue
            end
        endcase
    end

    // Slot storage. A write lands at the accepting edge, so a read of the
    // same slot by the next beat already sees it: no forwarding required.
    cfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_in_data.write_value),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (in_fire) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the status taken at acceptance; the RAM read
    // data holds too, since no new read issues while the pending stage waits.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend_ok    <= op_ok;
            r_pend_rd    <= op_rd;
            r_pend_count <= n_count;
            r_pend_full  <= n_count >= cap_use;
        end
        if (pend_move) begin
            r_out.accepted   <= r_pend_ok;
            r_out.read_value <= r_pend_rd ? ram_rdata : '0;
            r_out.occupancy  <= r_pend_count;
            r_out.is_empty   <= r_pend_count == '0;
            r_out.is_full    <= r_pend_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ bench/circular_fifo_queue_tb.sv @@
// Self-checking bench for circular_fifo_queue: random operations under flow control.
`timescale 1ns / 1ps

module circular_fifo_queue_tb;
    import cfq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 4;     // settle time after the last result beat
    localparam int SQUEEZE_CYCLES = 150;   // length of the long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
    localparam int REPORT_LIMIT   = 200;   // keep a broken run's log readable

    // Opcode outside the enum: the block must treat it as a no-op
    localparam t_opcode OP_UNDEFINED = t_opcode'(2'd3);

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'({REG_CAPACITY, 2'b00});

    // ------------------------------------------------------------------
    // Clock, reset and every block input, all known from time zero
    // ------------------------------------------------------------------
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    always #HALF_PERIOD i_clk = ~i_clk;

    circular_fifo_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_in_item  op_backlog[$];    // operations waiting to be offered
    t_out_item status_due[$];    // predicted result beats, oldest first
    int        ops_issued   = 0;
    int        ops_taken    = 0;
    int        fail_count   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_requests  = 0;
    int        holds_granted  = 0;
    int        hold_left      = 0;
    int        quiet_cycles   = 0;
    logic      in_beat        = 1'b0;

    // Mirror of the queue as the block should hold it
    logic signed [DATA_W-1:0] ring_mirror [DEPTH];
    int                       head_mirror  = 0;
    int                       tail_mirror  = 0;
    int                       count_mirror = 0;
    logic [CNT_W-1:0]         cap_mirror   = CAP_RESET;

    // Apply one operation to the mirror and return the status beat it should produce.
    // Capacity is clamped to 1..DEPTH; pointers wrap at the clamped value, so a
    // pointer left beyond a shrunk capacity falls back to slot 0 on its next advance.
    function automatic t_out_item predict_status(t_in_item op);
        t_out_item res;
        int        cap;
        cap = int'(cap_mirror);
        if (cap < 1)
            cap = 1;
        if (cap > DEPTH)
            cap = DEPTH;
        res = '0;
        case (op.opcode)
            OP_ENQUEUE: begin
                if (count_mirror < cap) begin
                    ring_mirror[tail_mirror] = op.write_value;
                    tail_mirror  = (tail_mirror + 1 >= cap) ? 0 : tail_mirror + 1;
                    count_mirror = count_mirror + 1;
                    res.accepted = 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (count_mirror != 0) begin
                    res.read_value = ring_mirror[head_mirror];
                    head_mirror  = (head_mirror + 1 >= cap) ? 0 : head_mirror + 1;
                    count_mirror = count_mirror - 1;
                    res.accepted = 1'b1;
                end
            end
            OP_PEEK: begin
                if (count_mirror != 0) begin
                    res.read_value = ring_mirror[head_mirror];
                    res.accepted   = 1'b1;
                end
            end
            default: ;  // unknown opcode: nothing moves
        endcase
        res.occupancy = CNT_W'(count_mirror);
        res.is_empty  = (count_mirror == 0);
        res.is_full   = (count_mirror >= cap);
        return res;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer operation beats, change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        // Hold valid and payload until the beat has gone through
        if (i_rst_n && (!i_in_valid || in_beat)) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= op_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side readiness: random stalls, plus the long hold-off when one is running
    always @(negedge i_clk) begin
        i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long hold-off: count it out here so the sender keeps pushing meanwhile
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_granted < hold_requests) begin
            hold_left     <= SQUEEZE_CYCLES;
            holds_granted <= holds_granted + 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_p
        t_out_item due;
        in_beat <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            // Predict the moment an operation beat is taken
            if (i_in_valid && o_in_ready) begin
                status_due.push_back(predict_status(i_in_data));
                ops_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: result beat with nothing outstanding, got %h",
                                 $time, o_out_data);
                    fail_count++;
                end else begin
                    due = status_due.pop_front();
                    check_field("accepted",   DATA_W'(due.accepted),   DATA_W'(o_out_data.accepted));
                    check_field("read_value", due.read_value,          o_out_data.read_value);
                    check_field("occupancy",  DATA_W'(due.occupancy),  DATA_W'(o_out_data.occupancy));
                    check_field("is_empty",   DATA_W'(due.is_empty),   DATA_W'(o_out_data.is_empty));
                    check_field("is_full",    DATA_W'(due.is_full),    DATA_W'(o_out_data.is_full));
                end
            end
        end
    end

    // Watchdog: give up once neither channel has moved for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_op(t_opcode code, logic [DATA_W-1:0] value);
        t_in_item op;
        op.opcode      = code;
        op.write_value = value;
        op_backlog.push_back(op);
        ops_issued++;
    endtask

    // Wait for every beat to be taken and answered, then let the pipeline settle
    task automatic wait_drained();
        while (ops_taken != ops_issued || status_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle then access cycle; pready is tied high so the write lands at once
    task automatic write_capacity(logic [CNT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_mirror = value;
        // Step clear of the clock edges before touching shared settings
        @(posedge i_clk);
        #1;
    endtask

    // Random operations in runs that lean towards filling or draining, so the
    // queue keeps hitting both full and empty at whatever capacity is set.
    task automatic queue_random_ops(int n);
        int               r;
        int               run_left;
        bit               filling;
        t_opcode          code;
        logic [DATA_W-1:0] value;
        run_left = 0;
        filling  = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(40, 5);
                filling  = ~filling;
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 3)
                code = OP_UNDEFINED;
            else if (r < 15)
                code = OP_PEEK;
            else if (r < 55)
                code = filling ? OP_ENQUEUE : OP_DEQUEUE;
            else if (r < 80)
                code = filling ? OP_ENQUEUE : OP_DEQUEUE;
            else
                code = filling ? OP_DEQUEUE : OP_ENQUEUE;
            // Mostly full-range words, now and then the extremes
            case ($urandom_range(19))
                0:       value = 32'h7FFF_FFFF;
                1:       value = 32'h8000_0000;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            queue_op(code, value);
        end
    endtask

    task automatic run_phase(logic [CNT_W-1:0] cap, int send_pct, int stall_pct, int n,
                             bit squeeze);
        write_capacity(cap);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (squeeze)
            hold_requests++;
        queue_random_ops(n);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Refusals on an empty queue, including the unknown opcode
        queue_op(OP_DEQUEUE, $urandom);
        queue_op(OP_PEEK, $urandom);
        queue_op(OP_UNDEFINED, $urandom);
        // Fill every slot at the reset capacity so that no later read can
        // land on a slot that was never written
        queue_op(OP_ENQUEUE, 32'h7FFF_FFFF);
        queue_op(OP_ENQUEUE, 32'h8000_0000);
        queue_op(OP_ENQUEUE, 32'h0000_0000);
        queue_op(OP_ENQUEUE, 32'hFFFF_FFFF);
        for (int k = 4; k < DEPTH; k++)
            queue_op(OP_ENQUEUE, $urandom);
        // Full: enqueue refused, peek still works, unknown opcode leaves it full
        queue_op(OP_ENQUEUE, $urandom);
        queue_op(OP_PEEK, $urandom);
        queue_op(OP_UNDEFINED, $urandom);
        wait_drained();

        // Shrink to zero (treated as one) while holding data: stays full,
        // head wraps straight back to slot 0
        write_capacity('0);
        queue_op(OP_DEQUEUE, $urandom);
        queue_op(OP_ENQUEUE, $urandom);
        queue_op(OP_PEEK, $urandom);
        wait_drained();

        // Random phases: capacity extremes and odd sizes, each idling mix
        run_phase(5'd31, 0,  0,  180, 1'b0);   // above depth: clamp to full size
        run_phase(5'd3,  53, 0,  180, 1'b0);
        run_phase(5'd1,  0,  53, 150, 1'b0);
        run_phase(5'd16, 25, 25, 200, 1'b0);
        run_phase(5'd17, 0,  0,  150, 1'b1);   // long hold-off backs up the input
        run_phase(5'd9,  0,  0,  200, 1'b0);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
